[design/gec_pkg.sv]
// ----------------------------------------------------------------------------
// gec_pkg: shared types and constants of the gravity escape-time cell
// Field layout, register indexes, controller states, datapath commands and
// fixed-point clipping helpers.
// ----------------------------------------------------------------------------
package gec_pkg;

  localparam int STAR_SLOTS = 8;
  localparam int SLOT_W     = (STAR_SLOTS > 1) ? $clog2(STAR_SLOTS) : 1;
  localparam int CNT_W      = $clog2(STAR_SLOTS + 1);
  localparam int FRAC       = 16;

  localparam int IN_W   = 232;
  localparam int OUT_W  = 24;
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;
  localparam int DIV_W  = 48;
  localparam int RAD_W  = 64;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_ITER_LIMIT = 4'd0;
  localparam logic [CFG_AW-1:0] REG_ESC_RADIUS = 4'd1;
  localparam logic [CFG_AW-1:0] REG_TIME_STEP  = 4'd2;
  localparam logic [CFG_AW-1:0] REG_GRAV       = 4'd3;
  localparam logic [CFG_AW-1:0] REG_STAR_COUNT = 4'd4;
  localparam logic [CFG_AW-1:0] REG_CENTER_X   = 4'd5;
  localparam logic [CFG_AW-1:0] REG_CENTER_Y   = 4'd6;
  localparam logic [CFG_AW-1:0] REG_CENTER_Z   = 4'd7;

  localparam logic [14:0] RST_ITER_LIMIT = 15'd1000;
  localparam logic [30:0] RST_ESC_RADIUS = 31'd655360;
  localparam logic [30:0] RST_TIME_STEP  = 31'd655;
  localparam logic [30:0] RST_GRAV       = 31'd65536;

  localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  localparam logic OPC_RENDER = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LIMIT, ST_EDIFF, ST_ESQ, ST_EER, ST_ETEST, ST_SDIFF, ST_SSQ,
    ST_SSUM, ST_SCHK, ST_SQRT, ST_FSEL, ST_FWAIT, ST_USTART, ST_UWAIT, ST_FU,
    ST_TERM, ST_AMUL, ST_AUPD, ST_VMUL, ST_VUPD, ST_DONE, ST_LDONE
  } gec_state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_EDIFF, OP_SQ, OP_EER, OP_ETEST, OP_SDIFF, OP_SSUM,
    OP_SCHK, OP_FSEL, OP_FDONE, OP_USTART, OP_UDONE, OP_FU, OP_TERM, OP_AMUL,
    OP_AUPD, OP_VMUL, OP_VUPD, OP_EMIT, OP_EMIT_ZERO
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   ax_clr;
    logic   ax_inc;
    logic   k_clr;
    logic   k_inc;
  } cmd_t;

  typedef struct packed {
    logic is_render;
    logic iter_done;
    logic esc_hit;
    logic star_none;
    logic star_last;
    logic ax_last;
    logic s2_zero;
    logic need_div;
    logic sqrt_busy;
    logic div_busy;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic        ovf;
    logic [31:0] val;
  } sat_t;

  // clip a 34-bit signed value to the signed 32-bit range
  function automatic sat_t clip34(input logic [33:0] v);
    sat_t r;
    r.ovf = (v[33:31] != 3'b000) && (v[33:31] != 3'b111);
    r.val = r.ovf ? (v[33] ? Q_MIN : Q_MAX) : v[31:0];
    return r;
  endfunction

  // clip a 48-bit signed value to the signed 32-bit range
  function automatic sat_t clip48(input logic [47:0] v);
    sat_t r;
    r.ovf = (v[47:31] != 17'h00000) && (v[47:31] != 17'h1ffff);
    r.val = r.ovf ? (v[47] ? Q_MIN : Q_MAX) : v[31:0];
    return r;
  endfunction

  function automatic logic [33:0] sext34(input logic [31:0] a);
    return {{2{a[31]}}, a};
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] a);
    return a[31] ? (~a + 32'd1) : a;
  endfunction

endpackage

[design/gec_div.sv]
// ----------------------------------------------------------------------------
// gec_div: iterative unsigned divider
// Restoring division of DIV_W-bit operands, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gec_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [gec_pkg::DIV_W-1:0] dividend_i,
  input  logic [gec_pkg::DIV_W-1:0] divisor_i,
  output logic                      busy_o,
  output logic [gec_pkg::DIV_W-1:0] quot_o
);
  import gec_pkg::*;

  localparam int CW = $clog2(DIV_W);

  logic [DIV_W-1:0] rem_q, quo_q, den_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic [DIV_W:0]   rem_sh, diff;
  logic             ge;

  // trial subtract of the shifted remainder
  always_comb begin
    rem_sh = {rem_q, quo_q[DIV_W-1]};
    diff   = rem_sh - {1'b0, den_q};
    ge     = rem_sh >= {1'b0, den_q};
  end

  // control: count the quotient bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(DIV_W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  // datapath: shift in one quotient bit a cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule

[design/gec_sqrt.sv]
// ----------------------------------------------------------------------------
// gec_sqrt: iterative integer square root
// Floor root of a RAD_W-bit radicand, one result bit per cycle.
// ----------------------------------------------------------------------------
module gec_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [gec_pkg::RAD_W-1:0] rad_i,
  output logic                      busy_o,
  output logic [gec_pkg::RAD_W/2-1:0] root_o
);
  import gec_pkg::*;

  logic [RAD_W-1:0] n_q, res_q, bit_q;
  logic [RAD_W-1:0] trial;
  logic             take;

  always_comb begin
    trial = res_q + bit_q;
    take  = n_q >= trial;
  end

  // control: the one-hot weight walks down two places a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= '0;
    end else if (start_i) begin
      bit_q <= {2'b01, {(RAD_W-2){1'b0}}};
    end else if (bit_q != '0) begin
      bit_q <= bit_q >> 2;
    end
  end

  // datapath: remainder and partial root
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= rad_i;
      res_q <= '0;
    end else if (bit_q != '0) begin
      if (take) begin
        n_q   <= n_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
    end
  end

  assign busy_o = bit_q != '0;
  assign root_o = res_q[RAD_W/2-1:0];

endmodule

[design/gec_datapath.sv]
// ----------------------------------------------------------------------------
// gec_datapath: registers, star table and arithmetic of the escape-time cell
// Holds configuration, particle state, the shared multiplier, the divider and
// the square-root unit, and the output register; acts on controller commands.
// ----------------------------------------------------------------------------
module gec_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [gec_pkg::IN_W-1:0]   s_tdata_i,
  input  logic                       s_tuser_i,
  input  logic                       cfg_valid_i,
  input  logic [gec_pkg::CFG_AW-1:0] cfg_addr_i,
  input  logic [gec_pkg::CFG_DW-1:0] cfg_data_i,
  input  logic                       m_tready_i,
  output logic                       m_tvalid_o,
  output logic [gec_pkg::OUT_W-1:0]  m_tdata_o,
  input  gec_pkg::cmd_t              cmd_i,
  output gec_pkg::sts_t              sts_o
);
  import gec_pkg::*;

  // configuration
  logic [14:0] lim_q;
  logic [30:0] er_q, dt_q, g_q;
  logic [3:0]  scnt_q;
  logic [31:0] ctr_q [3];

  // star table
  logic [31:0] sx_q [STAR_SLOTS];
  logic [31:0] sy_q [STAR_SLOTS];
  logic [31:0] sz_q [STAR_SLOTS];
  logic [30:0] sm_q [STAR_SLOTS];

  // particle and working registers
  logic [31:0] p_q [3], p_d [3];
  logic [31:0] v_q [3], v_d [3];
  logic [31:0] d_q [3], d_d [3];
  logic [31:0] acc_q [3], acc_d [3];
  logic [63:0] s2_q, s2_d, prod_q, prod_d;
  logic [30:0] gm_q, gm_d, f_q, f_d;
  logic [16:0] u_q, u_d;
  logic [14:0] iter_q, iter_d;
  logic        esc_q, esc_d, deg_q, deg_d, sat_q, sat_d;
  logic [1:0]  ax_q, ax_d;
  logic [SLOT_W-1:0] k_q, k_d;
  logic        ov_q, ov_d;
  logic [17:0] od_q, od_d;

  // input fields
  logic [2:0]  in_slot;
  logic [31:0] in_pos [3];
  logic [31:0] in_vel [3];
  logic [30:0] in_mass;

  logic [CNT_W-1:0] n_eff;
  logic [47:0]      s_val;
  logic [31:0]      mul_a, mul_b;
  logic             mul_en;
  logic             div_start, div_busy, sqrt_start, sqrt_busy;
  logic [DIV_W-1:0] div_num, div_den, div_q;
  logic [31:0]      root;
  logic             tbl_we;

  assign in_slot   = s_tdata_i[2:0];
  assign in_pos[0] = s_tdata_i[34:3];
  assign in_pos[1] = s_tdata_i[66:35];
  assign in_pos[2] = s_tdata_i[98:67];
  assign in_vel[0] = s_tdata_i[130:99];
  assign in_vel[1] = s_tdata_i[162:131];
  assign in_vel[2] = s_tdata_i[194:163];
  assign in_mass   = s_tdata_i[225:195];

  assign n_eff = (scnt_q > 4'(STAR_SLOTS)) ? CNT_W'(STAR_SLOTS) : CNT_W'(scnt_q);
  assign s_val = s2_q[63:FRAC];

  // status toward the controller
  always_comb begin
    sts_o.is_render = s_tuser_i == OPC_RENDER;
    sts_o.iter_done = iter_q == lim_q;
    sts_o.esc_hit   = s2_q > prod_q;
    sts_o.star_none = n_eff == '0;
    sts_o.star_last = (CNT_W'(k_q) + CNT_W'(1)) == n_eff;
    sts_o.ax_last   = ax_q == 2'd2;
    sts_o.s2_zero   = s2_q == '0;
    sts_o.need_div  = (gm_q != '0) && (s_val != '0);
    sts_o.sqrt_busy = sqrt_busy;
    sts_o.div_busy  = div_busy;
    sts_o.out_free  = !ov_q || m_tready_i;
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q    <= RST_ITER_LIMIT;
      er_q     <= RST_ESC_RADIUS;
      dt_q     <= RST_TIME_STEP;
      g_q      <= RST_GRAV;
      scnt_q   <= '0;
      ctr_q[0] <= '0;
      ctr_q[1] <= '0;
      ctr_q[2] <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        REG_ITER_LIMIT: lim_q    <= cfg_data_i[14:0];
        REG_ESC_RADIUS: er_q     <= cfg_data_i[30:0];
        REG_TIME_STEP:  dt_q     <= cfg_data_i[30:0];
        REG_GRAV:       g_q      <= cfg_data_i[30:0];
        REG_STAR_COUNT: scnt_q   <= cfg_data_i[3:0];
        REG_CENTER_X:   ctr_q[0] <= cfg_data_i;
        REG_CENTER_Y:   ctr_q[1] <= cfg_data_i;
        REG_CENTER_Z:   ctr_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // star table writes from load requests
  assign tbl_we = (cmd_i.op == OP_ACCEPT) && (s_tuser_i != OPC_RENDER) &&
                  (32'(in_slot) < STAR_SLOTS);

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      sx_q[in_slot[SLOT_W-1:0]] <= in_pos[0];
      sy_q[in_slot[SLOT_W-1:0]] <= in_pos[1];
      sz_q[in_slot[SLOT_W-1:0]] <= in_pos[2];
      sm_q[in_slot[SLOT_W-1:0]] <= in_mass;
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (cmd_i.op)
      OP_SQ: begin
        mul_a = mag32(d_q[ax_q]);
        mul_b = mag32(d_q[ax_q]);
      end
      OP_EER: begin
        mul_a = {1'b0, er_q};
        mul_b = {1'b0, er_q};
      end
      OP_SSUM: begin
        mul_a = {1'b0, g_q};
        mul_b = {1'b0, sm_q[k_q]};
      end
      OP_FU: begin
        mul_a = {1'b0, f_q};
        mul_b = {15'd0, u_q};
      end
      OP_AMUL: begin
        mul_a = mag32(acc_q[ax_q]);
        mul_b = {1'b0, dt_q};
      end
      OP_VMUL: begin
        mul_a = mag32(v_q[ax_q]);
        mul_b = {1'b0, dt_q};
      end
      default: mul_en = 1'b0;
    endcase
    prod_d = mul_en ? (64'(mul_a) * 64'(mul_b)) : prod_q;
  end

  // divider and root operands
  assign div_start  = (cmd_i.op == OP_USTART) ||
                      ((cmd_i.op == OP_FSEL) && sts_o.need_div);
  assign div_num    = (cmd_i.op == OP_FSEL) ? {1'b0, gm_q, 16'd0}
                                            : {mag32(d_q[ax_q]), 16'd0};
  assign div_den    = (cmd_i.op == OP_FSEL) ? s_val : {16'd0, root};
  assign sqrt_start = (cmd_i.op == OP_SCHK) && !sts_o.s2_zero;

  gec_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .busy_o     (div_busy),
    .quot_o     (div_q)
  );

  gec_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (s2_q),
    .busy_o  (sqrt_busy),
    .root_o  (root)
  );

  // next-state of the working registers
  always_comb begin
    sat_t        ra, rb;
    logic [31:0] c;
    logic [33:0] t34;
    logic [46:0] mp;
    logic [47:0] v48;

    for (int i = 0; i < 3; i++) begin
      p_d[i]   = p_q[i];
      v_d[i]   = v_q[i];
      d_d[i]   = d_q[i];
      acc_d[i] = acc_q[i];
    end
    s2_d   = s2_q;
    gm_d   = gm_q;
    f_d    = f_q;
    u_d    = u_q;
    iter_d = iter_q;
    esc_d  = esc_q;
    deg_d  = deg_q;
    sat_d  = sat_q;
    ov_d   = ov_q && !m_tready_i;
    od_d   = od_q;
    ra     = '0;
    rb     = '0;
    c      = prod_q[47:16];
    t34    = '0;
    mp     = prod_q[62:16];
    v48    = '0;

    case (cmd_i.op)
      OP_ACCEPT: begin
        if (s_tuser_i == OPC_RENDER) begin
          for (int i = 0; i < 3; i++) begin
            p_d[i] = in_pos[i];
            v_d[i] = in_vel[i];
          end
          iter_d = '0;
          esc_d  = 1'b0;
          deg_d  = 1'b0;
          sat_d  = 1'b0;
        end
      end
      OP_EDIFF: begin
        for (int i = 0; i < 3; i++) begin
          ra       = clip34(sext34(p_q[i]) - sext34(ctr_q[i]));
          d_d[i]   = ra.val;
          acc_d[i] = '0;
          if (ra.ovf) sat_d = 1'b1;
        end
      end
      OP_SDIFF: begin
        ra = clip34(sext34(p_q[0]) - sext34(sx_q[k_q]));
        d_d[0] = ra.val;
        if (ra.ovf) sat_d = 1'b1;
        ra = clip34(sext34(p_q[1]) - sext34(sy_q[k_q]));
        d_d[1] = ra.val;
        if (ra.ovf) sat_d = 1'b1;
        ra = clip34(sext34(p_q[2]) - sext34(sz_q[k_q]));
        d_d[2] = ra.val;
        if (ra.ovf) sat_d = 1'b1;
      end
      OP_SQ:   s2_d = (ax_q == 2'd0) ? 64'd0 : s2_q + prod_q;
      OP_EER:  s2_d = s2_q + prod_q;
      OP_SSUM: s2_d = s2_q + prod_q;
      OP_ETEST: begin
        if (sts_o.esc_hit) esc_d = 1'b1;
      end
      OP_SCHK: begin
        if (sts_o.s2_zero) begin
          deg_d = 1'b1;
        end else if (prod_q[63:47] != '0) begin
          gm_d  = Q_MAX[30:0];
          sat_d = 1'b1;
        end else begin
          gm_d = prod_q[46:16];
        end
      end
      OP_FSEL: begin
        if (gm_q == '0) begin
          f_d = '0;
        end else if (s_val == '0) begin
          f_d   = Q_MAX[30:0];
          sat_d = 1'b1;
        end
      end
      OP_FDONE: begin
        if (div_q[47:31] != '0) begin
          f_d   = Q_MAX[30:0];
          sat_d = 1'b1;
        end else begin
          f_d = div_q[30:0];
        end
      end
      OP_UDONE: u_d = div_q[16:0];
      OP_TERM: begin
        t34 = ($signed(d_q[ax_q]) > 0) ? (34'd0 - {2'b00, c}) : {2'b00, c};
        ra  = clip34(sext34(acc_q[ax_q]) + t34);
        acc_d[ax_q] = ra.val;
        if (ra.ovf) sat_d = 1'b1;
      end
      OP_AUPD: begin
        v48 = acc_q[ax_q][31] ? (48'd0 - {1'b0, mp}) : {1'b0, mp};
        ra  = clip48(v48);
        rb  = clip34(sext34(v_q[ax_q]) + sext34(ra.val));
        v_d[ax_q] = rb.val;
        if (ra.ovf || rb.ovf) sat_d = 1'b1;
      end
      OP_VUPD: begin
        v48 = v_q[ax_q][31] ? (48'd0 - {1'b0, mp}) : {1'b0, mp};
        ra  = clip48(v48);
        rb  = clip34(sext34(p_q[ax_q]) + sext34(ra.val));
        p_d[ax_q] = rb.val;
        if (ra.ovf || rb.ovf) sat_d = 1'b1;
        if (sts_o.ax_last) iter_d = iter_q + 15'd1;
      end
      OP_EMIT: begin
        ov_d = 1'b1;
        od_d = {sat_q, deg_q, esc_q, iter_q};
      end
      OP_EMIT_ZERO: begin
        ov_d = 1'b1;
        od_d = '0;
      end
      default: ;
    endcase

    // axis and star indexes
    if (cmd_i.ax_clr) ax_d = '0;
    else if (cmd_i.ax_inc) ax_d = ax_q + 2'd1;
    else ax_d = ax_q;
    if (cmd_i.k_clr) k_d = '0;
    else if (cmd_i.k_inc) k_d = k_q + SLOT_W'(1);
    else k_d = k_q;
  end

  // control and particle state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        p_q[i] <= '0;
        v_q[i] <= '0;
      end
      iter_q <= '0;
      esc_q  <= 1'b0;
      deg_q  <= 1'b0;
      sat_q  <= 1'b0;
      ax_q   <= '0;
      k_q    <= '0;
      ov_q   <= 1'b0;
    end else begin
      for (int i = 0; i < 3; i++) begin
        p_q[i] <= p_d[i];
        v_q[i] <= v_d[i];
      end
      iter_q <= iter_d;
      esc_q  <= esc_d;
      deg_q  <= deg_d;
      sat_q  <= sat_d;
      ax_q   <= ax_d;
      k_q    <= k_d;
      ov_q   <= ov_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      d_q[i]   <= d_d[i];
      acc_q[i] <= acc_d[i];
    end
    s2_q   <= s2_d;
    prod_q <= prod_d;
    gm_q   <= gm_d;
    f_q    <= f_d;
    u_q    <= u_d;
    od_q   <= od_d;
  end

  assign m_tvalid_o = ov_q;
  assign m_tdata_o  = {6'd0, od_q};

endmodule

[design/gec_ctrl.sv]
// ----------------------------------------------------------------------------
// gec_ctrl: sequencer of the escape-time cell
// Walks each integration step: escape test, per-star force terms, velocity
// and position updates, and issues at most one datapath command per cycle.
// ----------------------------------------------------------------------------
module gec_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output gec_pkg::cmd_t cmd_o,
  input  gec_pkg::sts_t sts_i
);
  import gec_pkg::*;

  gec_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_ACCEPT;
          state_d  = sts_i.is_render ? ST_LIMIT : ST_LDONE;
        end
      end
      ST_LIMIT: state_d = sts_i.iter_done ? ST_DONE : ST_EDIFF;
      ST_EDIFF: begin
        cmd_o.op     = OP_EDIFF;
        cmd_o.ax_clr = 1'b1;
        cmd_o.k_clr  = 1'b1;
        state_d      = ST_ESQ;
      end
      ST_ESQ: begin
        cmd_o.op = OP_SQ;
        if (sts_i.ax_last) begin
          cmd_o.ax_clr = 1'b1;
          state_d      = ST_EER;
        end else begin
          cmd_o.ax_inc = 1'b1;
        end
      end
      ST_EER: begin
        cmd_o.op = OP_EER;
        state_d  = ST_ETEST;
      end
      ST_ETEST: begin
        cmd_o.op = OP_ETEST;
        if (sts_i.esc_hit) state_d = ST_DONE;
        else if (sts_i.star_none) state_d = ST_AMUL;
        else state_d = ST_SDIFF;
      end
      ST_SDIFF: begin
        cmd_o.op = OP_SDIFF;
        state_d  = ST_SSQ;
      end
      ST_SSQ: begin
        cmd_o.op = OP_SQ;
        if (sts_i.ax_last) begin
          cmd_o.ax_clr = 1'b1;
          state_d      = ST_SSUM;
        end else begin
          cmd_o.ax_inc = 1'b1;
        end
      end
      ST_SSUM: begin
        cmd_o.op = OP_SSUM;
        state_d  = ST_SCHK;
      end
      ST_SCHK: begin
        cmd_o.op = OP_SCHK;
        if (!sts_i.s2_zero) begin
          state_d = ST_SQRT;
        end else if (sts_i.star_last) begin
          state_d = ST_AMUL;
        end else begin
          cmd_o.k_inc = 1'b1;
          state_d     = ST_SDIFF;
        end
      end
      ST_SQRT: begin
        if (!sts_i.sqrt_busy) state_d = ST_FSEL;
      end
      ST_FSEL: begin
        cmd_o.op = OP_FSEL;
        state_d  = sts_i.need_div ? ST_FWAIT : ST_USTART;
      end
      ST_FWAIT: begin
        if (!sts_i.div_busy) begin
          cmd_o.op = OP_FDONE;
          state_d  = ST_USTART;
        end
      end
      ST_USTART: begin
        cmd_o.op = OP_USTART;
        state_d  = ST_UWAIT;
      end
      ST_UWAIT: begin
        if (!sts_i.div_busy) begin
          cmd_o.op = OP_UDONE;
          state_d  = ST_FU;
        end
      end
      ST_FU: begin
        cmd_o.op = OP_FU;
        state_d  = ST_TERM;
      end
      ST_TERM: begin
        cmd_o.op = OP_TERM;
        if (!sts_i.ax_last) begin
          cmd_o.ax_inc = 1'b1;
          state_d      = ST_USTART;
        end else begin
          cmd_o.ax_clr = 1'b1;
          if (sts_i.star_last) begin
            state_d = ST_AMUL;
          end else begin
            cmd_o.k_inc = 1'b1;
            state_d     = ST_SDIFF;
          end
        end
      end
      ST_AMUL: begin
        cmd_o.op = OP_AMUL;
        state_d  = ST_AUPD;
      end
      ST_AUPD: begin
        cmd_o.op = OP_AUPD;
        if (sts_i.ax_last) begin
          cmd_o.ax_clr = 1'b1;
          state_d      = ST_VMUL;
        end else begin
          cmd_o.ax_inc = 1'b1;
          state_d      = ST_AMUL;
        end
      end
      ST_VMUL: begin
        cmd_o.op = OP_VMUL;
        state_d  = ST_VUPD;
      end
      ST_VUPD: begin
        cmd_o.op = OP_VUPD;
        if (sts_i.ax_last) begin
          cmd_o.ax_clr = 1'b1;
          state_d      = ST_LIMIT;
        end else begin
          cmd_o.ax_inc = 1'b1;
          state_d      = ST_VMUL;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_EMIT;
          state_d  = ST_IDLE;
        end
      end
      ST_LDONE: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_EMIT_ZERO;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

[design/gravity_escape_time_cell.sv]
// Each star term waits on the square root and on up to four passes of the divider,
// which produces one quotient bit per cycle. The next request is taken once the
// current one is finished, while its result may still wait in the output register.
// ----------------------------------------------------------------------------
// gravity_escape_time_cell: escape-time integration of a test particle
// Load requests fill the star table and return an all-zero result; render requests run
// semi-implicit Euler steps in Q16.16 and return the step count with escape,
// degenerate and saturation flags.
// ----------------------------------------------------------------------------
module gravity_escape_time_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // star_slot[2:0], pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, star_mass[30:0], zero pad
  input  logic [gec_pkg::IN_W-1:0]   s_axis_tdata_i,
  // opcode
  input  logic [0:0]                 s_axis_tuser_i,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // iterations[14:0], escaped, degenerate, saturated, zero pad
  output logic [gec_pkg::OUT_W-1:0]  m_axis_tdata_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [gec_pkg::CFG_AW-1:0] cfg_addr_i,
  input  logic [gec_pkg::CFG_DW-1:0] cfg_data_i
);
  import gec_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  gec_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  gec_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tdata_i   (s_axis_tdata_i),
    .s_tuser_i   (s_axis_tuser_i[0]),
    .cfg_valid_i (cfg_valid_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .m_tready_i  (m_axis_tready_i),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tdata_o   (m_axis_tdata_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

[design/gec_checker.sv]
// ----------------------------------------------------------------------------
// gec_checker: port-level checks of the escape-time cell
// Output hold rules, one request at a time, and the escape count bound.
// ----------------------------------------------------------------------------
module gec_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid_i,
  input logic                       s_axis_tready_o,
  input logic [gec_pkg::IN_W-1:0]   s_axis_tdata_i,
  input logic [0:0]                 s_axis_tuser_i,
  input logic                       m_axis_tvalid_o,
  input logic                       m_axis_tready_i,
  input logic [gec_pkg::OUT_W-1:0]  m_axis_tdata_o,
  input logic                       cfg_valid_i,
  input logic                       cfg_ready_o,
  input logic [gec_pkg::CFG_AW-1:0] cfg_addr_i,
  input logic [gec_pkg::CFG_DW-1:0] cfg_data_i
);
  import gec_pkg::*;

  logic [14:0] lim_q;
  logic        in_fire;

  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;

  // track the step limit as written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= RST_ITER_LIMIT;
    end else if (cfg_valid_i && cfg_ready_o && (cfg_addr_i == REG_ITER_LIMIT)) begin
      lim_q <= cfg_data_i[14:0];
    end
  end

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // take one request at a time
  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready_o)
    else $error("request taken while busy");

  // an escape happens before the step limit
  a_escape_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[15] |-> (m_axis_tdata_o[14:0] < lim_q))
    else $error("escape reported at or past the limit");

endmodule

bind gravity_escape_time_cell gec_checker u_gec_checker (.*);
